@@ design/frdp_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed decimal reply parser package
// Character codes, result types and the decimal digit folding function.
// ----------------------------------------------------------------------------
package frdp_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPEED = 8'h73;
    localparam logic [7:0] CH_STEPS = 8'h70;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned VALUE_W = 17;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 17'd99999;

    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_STEPS = 1'b1;

    // Shortest line that can hold a reply: hash, command, one digit, hash.
    localparam int unsigned MIN_LINE = 4;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               started;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc * 10 + digit, saturating at VALUE_MAX.
    function automatic logic [VALUE_W-1:0] fold_digit(
        input logic [VALUE_W-1:0] acc,
        input logic [7:0]         c
    );
        logic [VALUE_W+3:0] wide;
        wide = ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}) + {{(VALUE_W){1'b0}}, c[3:0]};
        if (wide > {4'b0000, VALUE_MAX})
        begin
            return VALUE_MAX;
        end
        return wide[VALUE_W-1:0];
    endfunction

endpackage

@@ design/frdp_line_tracker.sv @@
// ----------------------------------------------------------------------------
// Line tracker
// Keeps a running summary of the current line and decides on line feed.
// ----------------------------------------------------------------------------
module frdp_line_tracker #(
    parameter int unsigned MAX_CHARS = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output frdp_pkg::result_t res
);
    import frdp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_CHARS + 2);

    logic [CNT_W-1:0]   pending_reg, pending_next;
    logic               started_reg, started_next;
    logic               first_hash_reg;
    logic               cmd_s_reg;
    logic               cmd_p_reg;
    logic [7:0]         last_reg;
    logic               digits_ok_reg;
    logic [VALUE_W-1:0] acc_reg;

    logic [CNT_W-1:0]   cnt;
    logic               line_ok;

    // A line that grew past the limit is dropped before the byte is handled.
    assign cnt = (pending_reg > CNT_W'(MAX_CHARS)) ? '0 : pending_reg;

    // The digit run covers positions 2 up to the byte before the last one.
    assign line_ok = (cnt >= CNT_W'(MIN_LINE)) && first_hash_reg &&
                     (cmd_s_reg || cmd_p_reg) && (last_reg == CH_HASH) &&
                     digits_ok_reg;

    always_comb
    begin
        pending_next = pending_reg;
        started_next = started_reg;
        res          = '0;
        res.value    = acc_reg;
        res.kind     = cmd_s_reg ? KIND_SPEED : KIND_STEPS;
        if (step)
        begin
            if (rx_byte == CH_CR)
            begin
                pending_next = cnt;
            end
            else if (rx_byte != CH_LF)
            begin
                pending_next = cnt + CNT_W'(1);
            end
            else
            begin
                pending_next = '0;
                res.valid    = line_ok;
                started_next = started_reg | (line_ok & cmd_s_reg);
            end
        end
        res.started = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && (rx_byte != CH_CR) && (rx_byte != CH_LF))
        begin
            last_reg <= rx_byte;
            if (cnt == CNT_W'(0))
            begin
                first_hash_reg <= (rx_byte == CH_HASH);
            end
            if (cnt == CNT_W'(1))
            begin
                cmd_s_reg <= (rx_byte == CH_SPEED);
                cmd_p_reg <= (rx_byte == CH_STEPS);
            end
            if (cnt <= CNT_W'(2))
            begin
                digits_ok_reg <= 1'b1;
                acc_reg       <= '0;
            end
            else
            begin
                // The previous byte is now known not to be the closing hash.
                digits_ok_reg <= digits_ok_reg & is_digit(last_reg);
                acc_reg       <= fold_digit(acc_reg, last_reg);
            end
        end
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(MAX_CHARS + 1))
        else $error("line count beyond the line depth");

    a_result_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (step && (rx_byte == CH_LF)))
        else $error("result raised without a line feed");

    a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

endmodule

@@ design/framed_decimal_reply_parser.sv @@
// ----------------------------------------------------------------------------
// Framed decimal reply parser
// Parses '#s<digits>#' and '#p<digits>#' reply lines from a byte stream.
// ----------------------------------------------------------------------------
// A line feed byte is held in the input register and its result in the result
// register. Throughput: one byte per cycle when the result side does not stall;
// the line summary is updated in one pass.
// Reset clears the line count, the started flag and both valid flags.
module framed_decimal_reply_parser #(
    parameter int unsigned MAX_CHARS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] value, [17] stream_started, zero fill
    output logic        m_axis_tuser    // [0] value_kind
);
    import frdp_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_started_reg;

    logic               out_free;
    logic               step;
    result_t            res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    frdp_line_tracker #(
        .MAX_CHARS (MAX_CHARS)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (out_free && res.valid)
        begin
            out_kind_reg    <= res.kind;
            out_value_reg   <= res.value;
            out_started_reg <= res.started;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_started_reg, out_value_reg};
    assign m_axis_tuser  = out_kind_reg;

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= VALUE_MAX))
        else $error("reply value above the saturation limit");

    a_speed_started: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SPEED)) |-> m_axis_tdata[17])
        else $error("speed reply without the started flag");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending byte lost while the result side stalls");

endmodule

@@ verif/framed_decimal_reply_parser_tb.sv @@
// ----------------------------------------------------------------------------
// Framed decimal reply parser testbench
// Streams received bytes into the parser and compares every reply with a
// line-by-line prediction of the parser. A short directed part covers the
// framing corner cases. A random part of well-formed, damaged and noise
// lines follows. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module framed_decimal_reply_parser_tb;

    import frdp_pkg::*;

    localparam int unsigned MAX_CHARS    = 7;
    localparam int unsigned LINE_DEPTH   = MAX_CHARS + 1;
    localparam int unsigned RANDOM_BYTES = 1500;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               started;
    } reply_t;

    // Tracks the line being assembled and queues the replies it must produce.
    class reply_tracker;
        logic [7:0]  line_buf [LINE_DEPTH];
        int unsigned fill;
        bit          speed_seen;
        reply_t      expected_replies [$];
        int unsigned errors;
        int unsigned speed_replies;
        int unsigned step_replies;

        function new();
            fill       = 0;
            speed_seen = 1'b0;
            errors     = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned len;
            int unsigned acc;
            logic [7:0]  cmd;
            reply_t      r;
            // A line that has grown past the limit is thrown away first.
            if (fill > MAX_CHARS)
            begin
                fill = 0;
            end
            if (b == CH_CR)
            begin
                return;
            end
            if (b != CH_LF)
            begin
                if (fill < LINE_DEPTH)
                begin
                    line_buf[fill] = b;
                    fill++;
                end
                return;
            end
            len  = fill;
            fill = 0;
            if (len < MIN_LINE)
            begin
                return;
            end
            if (line_buf[0] != CH_HASH || line_buf[len-1] != CH_HASH)
            begin
                return;
            end
            cmd = line_buf[1];
            if (cmd != CH_SPEED && cmd != CH_STEPS)
            begin
                return;
            end
            acc = 0;
            for (int i = 2; i < len - 1; i++)
            begin
                if (line_buf[i] < CH_ZERO || line_buf[i] > CH_NINE)
                begin
                    return;
                end
                acc = acc * 10 + (line_buf[i] - CH_ZERO);
                if (acc > VALUE_MAX)
                begin
                    acc = VALUE_MAX;
                end
            end
            if (cmd == CH_SPEED)
            begin
                speed_seen = 1'b1;
            end
            r.kind    = (cmd == CH_SPEED) ? KIND_SPEED : KIND_STEPS;
            r.value   = acc[VALUE_W-1:0];
            r.started = speed_seen;
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic kind, logic [VALUE_W-1:0] value, logic started);
            reply_t exp_r;
            if (expected_replies.size() == 0)
            begin
                $error("unexpected reply: kind %0d value %0d started %0d",
                       kind, value, started);
                errors++;
                return;
            end
            exp_r = expected_replies.pop_front();
            if (kind !== exp_r.kind)
            begin
                $error("value_kind: expected %0d, actual %0d", exp_r.kind, kind);
                errors++;
            end
            if (value !== exp_r.value)
            begin
                $error("value: expected %0d, actual %0d", exp_r.value, value);
                errors++;
            end
            if (started !== exp_r.started)
            begin
                $error("stream_started: expected %0d, actual %0d", exp_r.started, started);
                errors++;
            end
            if (exp_r.kind == KIND_SPEED)
            begin
                speed_replies++;
            end
            else
            begin
                step_replies++;
            end
        endfunction
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    bit           calm = 1'b0;
    int unsigned  bytes_sent = 0;
    int unsigned  cycles = 0;
    reply_tracker tracker = new();

    framed_decimal_reply_parser #(
        .MAX_CHARS(MAX_CHARS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.take_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_reply(m_axis_tuser, m_axis_tdata[VALUE_W-1:0],
                                    m_axis_tdata[VALUE_W]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.expected_replies.size() != 0);
    endtask

    task automatic run_directed();
        // Step count reply before any speed reply: started must still be low.
        send_text("#p7#");
        send_byte(CH_LF);
        send_text("#s99999#");
        send_byte(CH_LF);
        // Carriage returns inside and at the end of a line are dropped.
        send_text("#s");
        send_byte(CH_CR);
        send_text("0#");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_text("#s#");
        send_byte(CH_LF);
        send_text("#x5#");
        send_byte(CH_LF);
        send_text("#s1a#");
        send_byte(CH_LF);
        send_text("#p1");
        send_byte(8'h00);
        send_text("#");
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_text("s12#");
        send_byte(CH_LF);
        send_text("#p12");
        send_byte(CH_LF);
        // Overlong lines: the ninth byte, a carriage return or a line feed
        // each find the line full and discard it first.
        send_text("#s1234567#");
        send_byte(CH_LF);
        send_text("#s123456");
        send_byte(CH_LF);
        send_text("#s123456");
        send_byte(CH_CR);
        send_text("#p3#");
        send_byte(CH_LF);
        send_text("#p00042#");
        send_byte(CH_LF);
    endtask

    task automatic run_random();
        logic [7:0]  frame [$];
        int unsigned start;
        int unsigned pick;
        int unsigned line_no;
        start   = bytes_sent;
        line_no = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            calm <= (line_no >= 80 && line_no < 200);
            if (line_no == 60)
            begin
                wait_for_replies();
            end
            frame.delete();
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                frame.push_back(CH_HASH);
                frame.push_back($urandom_range(1) ? CH_SPEED : CH_STEPS);
                repeat ($urandom_range(5, 1))
                begin
                    frame.push_back(8'(CH_ZERO + $urandom_range(9)));
                end
                frame.push_back(CH_HASH);
                // Some lines are damaged: a byte replaced, dropped, or extra
                // digits that can push the line past its limit.
                if (pick >= 70)
                begin
                    case ($urandom_range(2))
                        0: frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
                        1: frame.delete($urandom_range(frame.size() - 1));
                        default:
                        begin
                            repeat ($urandom_range(4, 1))
                            begin
                                frame.insert($urandom_range(frame.size()),
                                             8'(CH_ZERO + $urandom_range(9)));
                            end
                        end
                    endcase
                end
                if ($urandom_range(9) == 0)
                begin
                    frame.insert($urandom_range(frame.size()), CH_CR);
                end
                frame.push_back(CH_LF);
            end
            else
            begin
                repeat ($urandom_range(12, 1))
                begin
                    frame.push_back(8'($urandom_range(255)));
                end
                if ($urandom_range(1))
                begin
                    frame.push_back(CH_LF);
                end
            end
            foreach (frame[i])
            begin
                send_byte(frame[i]);
            end
            line_no++;
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_for_replies();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes of framed, damaged and noise lines.", bytes_sent);
        $display("Checked %0d speed and %0d step count replies.",
                 tracker.speed_replies, tracker.step_replies);
        if (tracker.errors == 0 && tracker.expected_replies.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
